### rtl/sci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sci_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int COST_W = 32;
   localparam int TAG_W  = 16;
   localparam int OP_W   = 2;
   localparam int CAP_W  = 7;
   localparam int RANK_W = 6;
   localparam int POS_W  = 7;
   localparam int CMP_W  = CNT_W + RANK_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic start;
      logic scan_rd;
      logic shift;
      logic place;
      logic read_cap;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic t_zero;
      logic entry_ge;
      logic rsp_free;
   } status_type;

   // clamp capacity register to 1..DEPTH
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] value);
      logic [CNT_W-1:0] res;
      if (value == '0) begin
         res = CNT_W'(1);
      end else if (int'(value) > DEPTH) begin
         res = CNT_W'(DEPTH);
      end else begin
         res = CNT_W'(value);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/sci_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sci_ctrl
   import sci_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire op_type     req_op,
   input  wire logic       csr_valid,
   input  wire status_type status,
   output logic            req_ready,
   output logic            csr_ready,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) begin
               unique case (req_op)
                  OP_INSERT: state_in = ST_SCAN_RD;
                  OP_READ:   state_in = ST_READ_WAIT;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = status.t_zero ? ST_RESP : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = status.entry_ge ? ST_SCAN_RD : ST_RESP;
         end
         ST_READ_WAIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !csr_valid;
            csr_ready = 1'b1;
            cmd.start = req_valid && !csr_valid;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = !status.t_zero;
            cmd.place   = status.t_zero;
         end
         ST_SCAN_CMP: begin
            cmd.shift = status.entry_ge;
            cmd.place = !status.entry_ge;
         end
         ST_READ_WAIT: begin
            cmd.read_cap = 1'b1;
         end
         ST_RESP: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   ast_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.scan_rd, cmd.shift, cmd.place, cmd.read_cap, cmd.load_rsp}))
      else $error("more than one datapath command");

   ast_no_dual_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && csr_valid && csr_ready))
      else $error("request and csr write in the same cycle");

   ast_place_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> state_ff == ST_RESP)
      else $error("placement not followed by response");

endmodule

`default_nettype wire

### rtl/sci_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sci_datapath
   import sci_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire op_type              req_op,
   input  wire logic [COST_W-1:0]   req_cost,
   input  wire logic [TAG_W-1:0]    req_tag,
   input  wire logic [RANK_W-1:0]   req_rank,
   input  wire logic                csr_we,
   input  wire logic [CAP_W-1:0]    csr_capacity,
   input  wire logic                rsp_ready,
   output status_type               status,
   output logic                     rsp_valid,
   output logic [POS_W-1:0]         rsp_position,
   output logic                     rsp_dropped,
   output logic [TAG_W-1:0]         rsp_dropped_tag,
   output logic [COST_W-1:0]        rsp_read_cost,
   output logic [TAG_W-1:0]         rsp_read_tag,
   output logic                     rsp_read_valid,
   output logic [POS_W-1:0]         rsp_fill
);

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   logic [CNT_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  t_ff;
   logic [COST_W-1:0] cost_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [RANK_W-1:0] rank_ff;

   logic [POS_W-1:0]  res_pos_ff;
   logic              res_dropped_ff;
   logic [TAG_W-1:0]  res_dtag_ff;
   logic [COST_W-1:0] res_rcost_ff;
   logic [TAG_W-1:0]  res_rtag_ff;
   logic              res_rvalid_ff;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_dropped_ff;
   logic [TAG_W-1:0]  rsp_dtag_ff;
   logic [COST_W-1:0] rsp_rcost_ff;
   logic [TAG_W-1:0]  rsp_rtag_ff;
   logic              rsp_rvalid_ff;
   logic [POS_W-1:0]  rsp_fill_ff;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   entry_type         wr_data;
   logic              t_at_cap;
   logic              rank_ok;
   logic [CNT_W-1:0]  new_cap;

   always_comb begin
      t_at_cap = (t_ff == cap_ff);
      rank_ok  = CMP_W'(rank_ff) < CMP_W'(fill_ff);
      new_cap  = eff_cap(csr_capacity);
      rd_en    = cmd.scan_rd || (cmd.start && req_op == OP_READ);
      rd_addr  = cmd.start ? ADDR_W'(req_rank) : ADDR_W'(t_ff - CNT_W'(1));
      wr_en    = (cmd.shift || cmd.place) && !t_at_cap;
      wr_data  = cmd.shift ? rdata_ff : entry_type'({cost_ff, tag_ff});
      status.t_zero   = (t_ff == '0);
      status.entry_ge = (rdata_ff.cost >= cost_ff);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ADDR_W'(t_ff)] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= eff_cap(CAP_W'(DEPTH));
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= new_cap;
            if (fill_ff > new_cap) begin
               fill_ff <= new_cap;
            end
         end else if (cmd.start && req_op == OP_CLEAR) begin
            fill_ff <= '0;
         end else if (cmd.place && fill_ff < cap_ff) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cost_ff        <= req_cost;
         tag_ff         <= req_tag;
         rank_ff        <= req_rank;
         t_ff           <= fill_ff;
         res_pos_ff     <= '0;
         res_dropped_ff <= 1'b0;
         res_dtag_ff    <= '0;
         res_rcost_ff   <= '0;
         res_rtag_ff    <= '0;
         res_rvalid_ff  <= 1'b0;
      end
      if (cmd.shift) begin
         t_ff <= t_ff - CNT_W'(1);
         if (t_at_cap) begin
            res_dropped_ff <= 1'b1;
            res_dtag_ff    <= rdata_ff.tag;
         end
      end
      if (cmd.place) begin
         res_pos_ff <= POS_W'(t_ff);
         if (t_at_cap) begin
            res_dropped_ff <= 1'b1;
            res_dtag_ff    <= tag_ff;
         end
      end
      if (cmd.read_cap && rank_ok) begin
         res_rvalid_ff <= 1'b1;
         res_rcost_ff  <= rdata_ff.cost;
         res_rtag_ff   <= rdata_ff.tag;
      end
      if (cmd.load_rsp) begin
         rsp_pos_ff     <= res_pos_ff;
         rsp_dropped_ff <= res_dropped_ff;
         rsp_dtag_ff    <= res_dtag_ff;
         rsp_rcost_ff   <= res_rcost_ff;
         rsp_rtag_ff    <= res_rtag_ff;
         rsp_rvalid_ff  <= res_rvalid_ff;
         rsp_fill_ff    <= POS_W'(fill_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_dropped     = rsp_dropped_ff;
   assign rsp_dropped_tag = rsp_dtag_ff;
   assign rsp_read_cost   = rsp_rcost_ff;
   assign rsp_read_tag    = rsp_rtag_ff;
   assign rsp_read_valid  = rsp_rvalid_ff;
   assign rsp_fill        = rsp_fill_ff;

   ast_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill count above capacity");

   ast_cap_range: assert property (@(posedge clock) disable iff (reset)
      cap_ff != '0 && int'(cap_ff) <= DEPTH)
      else $error("effective capacity out of range");

   ast_shift_step: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |=> t_ff == $past(t_ff) - CNT_W'(1))
      else $error("scan index did not step down");

endmodule

`default_nettype wire

### rtl/sorted_cost_insert_table_top.sv
// Insert: a backward scan from the fill count reads one entry at a time and moves it up
//   while its cost is not below the new cost, then places the new entry in the gap.
// Read: registered memory read. Clear and no-op go straight to the response.
// One request in flight; the next is taken once the response is registered.
// Synchronous reset empties the table and sets capacity to 64; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_cost_insert_table_top
   import sci_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [COST_W-1:0]   req_cost,
   input  wire logic [TAG_W-1:0]    req_tag,
   input  wire logic [RANK_W-1:0]   req_rank,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [POS_W-1:0]         rsp_position,
   output logic                     rsp_dropped,
   output logic [TAG_W-1:0]         rsp_dropped_tag,
   output logic [COST_W-1:0]        rsp_read_cost,
   output logic [TAG_W-1:0]         rsp_read_tag,
   output logic                     rsp_read_valid,
   output logic [POS_W-1:0]         rsp_fill,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_W-1:0]    csr_capacity
);

   cmd_type    cmd;
   status_type status;
   op_type     op;

   assign op = op_type'(req_op);

   sci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (op),
      .csr_valid (csr_valid),
      .status    (status),
      .req_ready (req_ready),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   sci_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (op),
      .req_cost        (req_cost),
      .req_tag         (req_tag),
      .req_rank        (req_rank),
      .csr_we          (csr_valid && csr_ready),
      .csr_capacity    (csr_capacity),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_position    (rsp_position),
      .rsp_dropped     (rsp_dropped),
      .rsp_dropped_tag (rsp_dropped_tag),
      .rsp_read_cost   (rsp_read_cost),
      .rsp_read_tag    (rsp_read_tag),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_fill        (rsp_fill)
   );

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sci_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 140;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 105;
   localparam int PRINT_LIMIT  = 100;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic              dropped;
      logic [TAG_W-1:0]  dropped_tag;
      logic [COST_W-1:0] read_cost;
      logic [TAG_W-1:0]  read_tag;
      logic              read_valid;
      logic [POS_W-1:0]  fill;
   } outcome_type;

   typedef struct packed {
      bit                is_csr;
      logic [CAP_W-1:0]  capacity;
      op_type            op;
      logic [COST_W-1:0] cost;
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] rank;
      bit                typed;
      outcome_type       want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [OP_W-1:0]     req_op = OP_NOP;
   logic [COST_W-1:0]   req_cost = '0;
   logic [TAG_W-1:0]    req_tag = '0;
   logic [RANK_W-1:0]   req_rank = '0;
   logic                rsp_ready = 1'b0;
   logic                csr_valid = 1'b0;
   logic [CAP_W-1:0]    csr_capacity = '0;
   logic                req_ready;
   logic                rsp_valid;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_dropped;
   logic [TAG_W-1:0]    rsp_dropped_tag;
   logic [COST_W-1:0]   rsp_read_cost;
   logic [TAG_W-1:0]    rsp_read_tag;
   logic                rsp_read_valid;
   logic [POS_W-1:0]    rsp_fill;
   logic                csr_ready;

   // shadow of the table
   logic [COST_W-1:0]   cost_table [DEPTH];
   logic [TAG_W-1:0]    tag_table [DEPTH];
   int                  table_fill = 0;
   logic [CAP_W-1:0]    capacity_reg = 7'd64;

   outcome_type         expected_outcomes [$];
   stim_row_type        directed_rows [$];
   int                  error_count = 0;
   int                  response_count = 0;
   int                  cycle_count = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_idle_pct = 0;

   sorted_cost_insert_table_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_cost        (req_cost),
      .req_tag         (req_tag),
      .req_rank        (req_rank),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_dropped     (rsp_dropped),
      .rsp_dropped_tag (rsp_dropped_tag),
      .rsp_read_cost   (rsp_read_cost),
      .rsp_read_tag    (rsp_read_tag),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_fill        (rsp_fill),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int effective_capacity();
      int cap;
      cap = int'(capacity_reg);
      if (cap < 1) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      return cap;
   endfunction

   function automatic outcome_type apply_request(input op_type op,
                                                 input logic [COST_W-1:0] cost,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [RANK_W-1:0] rank);
      outcome_type res;
      int cap, n, p, i;
      res = '0;
      cap = effective_capacity();
      n = table_fill;
      if (n > cap) n = cap;
      case (op)
         OP_INSERT: begin
            p = n;
            for (i = n - 1; i >= 0; i--) begin
               if (cost_table[i] >= cost) p = i;
            end
            if (n < cap) begin
               for (i = n; i > p; i--) begin
                  cost_table[i] = cost_table[i-1];
                  tag_table[i] = tag_table[i-1];
               end
               cost_table[p] = cost;
               tag_table[p] = tag;
               n++;
               res.position = POS_W'(p);
            end else if (p < cap) begin
               res.dropped = 1'b1;
               res.dropped_tag = tag_table[cap-1];
               for (i = cap - 1; i > p; i--) begin
                  cost_table[i] = cost_table[i-1];
                  tag_table[i] = tag_table[i-1];
               end
               cost_table[p] = cost;
               tag_table[p] = tag;
               res.position = POS_W'(p);
            end else begin
               // full and no better than the worst: refused
               res.dropped = 1'b1;
               res.dropped_tag = tag;
               res.position = POS_W'(cap);
            end
         end
         OP_READ: begin
            if (int'(rank) < n) begin
               res.read_valid = 1'b1;
               res.read_cost = cost_table[rank];
               res.read_tag = tag_table[rank];
            end
         end
         OP_CLEAR: n = 0;
         default: ;
      endcase
      table_fill = n;
      res.fill = POS_W'(n);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s got %h expected %h",
                                   response_count, name, got, want));
   endtask

   task automatic add_request(input op_type op, input logic [COST_W-1:0] cost,
                              input logic [TAG_W-1:0] tag, input logic [RANK_W-1:0] rank);
      stim_row_type row;
      row = '0;
      row.op = op;
      row.cost = cost;
      row.tag = tag;
      row.rank = rank;
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_typed(input op_type op, input logic [COST_W-1:0] cost,
                            input logic [TAG_W-1:0] tag, input logic [RANK_W-1:0] rank,
                            input int position, input bit dropped,
                            input logic [TAG_W-1:0] dropped_tag,
                            input logic [COST_W-1:0] read_cost,
                            input logic [TAG_W-1:0] read_tag, input bit read_valid,
                            input int fill);
      stim_row_type row;
      row = '0;
      row.op = op;
      row.cost = cost;
      row.tag = tag;
      row.rank = rank;
      row.typed = 1'b1;
      row.want.position = POS_W'(position);
      row.want.dropped = dropped;
      row.want.dropped_tag = dropped_tag;
      row.want.read_cost = read_cost;
      row.want.read_tag = read_tag;
      row.want.read_valid = read_valid;
      row.want.fill = POS_W'(fill);
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_csr(input logic [CAP_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.capacity = value;
      directed_rows = {directed_rows, row};
   endtask

   task automatic send_request(input op_type op, input logic [COST_W-1:0] cost,
                               input logic [TAG_W-1:0] tag, input logic [RANK_W-1:0] rank);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_cost <= cost;
      req_tag <= tag;
      req_rank <= rank;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // only while idle: every expected response has come back
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      int cap;
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_capacity <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      capacity_reg = value;
      cap = effective_capacity();
      if (table_fill > cap) table_fill = cap;
   endtask

   always @(posedge clock) begin : response_check
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding",
                                         response_count));
            end else begin
               want = expected_outcomes.pop_front();
               check_field("position", 32'(rsp_position), 32'(want.position));
               check_field("dropped", 32'(rsp_dropped), 32'(want.dropped));
               check_field("dropped_tag", 32'(rsp_dropped_tag), 32'(want.dropped_tag));
               check_field("read_cost", rsp_read_cost, want.read_cost);
               check_field("read_tag", 32'(rsp_read_tag), 32'(want.read_tag));
               check_field("read_valid", 32'(rsp_read_valid), 32'(want.read_valid));
               check_field("fill", 32'(rsp_fill), 32'(want.fill));
            end
            response_count++;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      stim_row_type      row;
      outcome_type       predicted;
      op_type            op;
      logic [COST_W-1:0] cost;
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] rank;
      logic [CAP_W-1:0]  phase_caps [PHASES];
      int                phase, k, w;

      add_typed(OP_NOP, 32'd0, 16'd0, 6'd0, 0, 0, 16'd0, 32'd0, 16'd0, 0, 0);
      add_typed(OP_INSERT, 32'd100, 16'h0001, 6'd0, 0, 0, 16'd0, 32'd0, 16'd0, 0, 1);
      add_typed(OP_CLEAR, 32'd0, 16'd0, 6'd0, 0, 0, 16'd0, 32'd0, 16'd0, 0, 0);
      add_csr(7'd3);
      add_typed(OP_INSERT, 32'd100, 16'h0001, 6'd0, 0, 0, 16'd0, 32'd0, 16'd0, 0, 1);
      add_typed(OP_INSERT, 32'd0, 16'h0000, 6'd0, 0, 0, 16'd0, 32'd0, 16'd0, 0, 2);
      add_typed(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 6'd0,
                2, 0, 16'd0, 32'd0, 16'd0, 0, 3);
      // tie goes in front, worst pushed out
      add_typed(OP_INSERT, 32'd100, 16'h0002, 6'd0, 1, 1, 16'hFFFF, 32'd0, 16'd0, 0, 3);
      // full, not better than the worst: refused
      add_typed(OP_INSERT, 32'hFFFF_FFFF, 16'h0003, 6'd0,
                3, 1, 16'h0003, 32'd0, 16'd0, 0, 3);
      add_request(OP_READ, 32'd0, 16'd0, 6'd0);
      add_request(OP_READ, 32'd0, 16'd0, 6'd1);
      add_request(OP_READ, 32'd0, 16'd0, 6'd2);
      add_typed(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 0, 0, 16'd0, 32'd0, 16'd0, 0, 3);
      // zero capacity acts as one, table cut to a single entry
      add_csr(7'd0);
      add_request(OP_READ, 32'd0, 16'd0, 6'd0);
      add_typed(OP_READ, 32'd0, 16'd0, 6'd1, 0, 0, 16'd0, 32'd0, 16'd0, 0, 1);
      add_typed(OP_INSERT, 32'd0, 16'h5A5A, 6'd0, 0, 1, 16'h0000, 32'd0, 16'd0, 0, 1);
      add_typed(OP_INSERT, 32'hFFFF_FFFF, 16'h1234, 6'd0,
                1, 1, 16'h1234, 32'd0, 16'd0, 0, 1);
      add_csr(7'd127);
      add_request(OP_INSERT, 32'h8000_0000, 16'h8000, 6'd0);
      add_request(OP_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 6'd0);
      add_request(OP_READ, 32'd0, 16'd0, 6'd1);
      add_request(OP_READ, 32'd0, 16'd0, 6'd2);
      add_typed(OP_CLEAR, 32'd0, 16'd0, 6'd0, 0, 0, 16'd0, 32'd0, 16'd0, 0, 0);

      phase_caps[0] = 7'd64;
      phase_caps[1] = 7'd100;
      phase_caps[2] = 7'd5;
      phase_caps[3] = 7'd0;
      phase_caps[4] = 7'd2;
      phase_caps[5] = 7'd127;
      phase_caps[6] = 7'd1;
      phase_caps[7] = 7'd64;
      phase_caps[8] = CAP_W'($urandom_range(1, DEPTH));

      sender_idle_pct = 28;
      receiver_idle_pct = 46;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.is_csr) begin
            write_capacity(row.capacity);
         end else begin
            send_request(row.op, row.cost, row.tag, row.rank);
            predicted = apply_request(row.op, row.cost, row.tag, row.rank);
            expected_outcomes = {expected_outcomes, (row.typed ? row.want : predicted)};
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         sender_idle_pct = (phase < 3) ? 28 : (phase < 6) ? 46 : 0;
         receiver_idle_pct = (phase < 3) ? 46 : (phase < 6) ? 28 : 0;
         write_capacity(phase_caps[phase]);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            w = $urandom_range(0, 999);
            if (w < 620) op = OP_INSERT;
            else if (w < 930) op = OP_READ;
            else if (w < 995) op = OP_NOP;
            else op = OP_CLEAR;
            case ($urandom_range(0, 3))
               0: cost = $urandom_range(0, 7);
               1: cost = $urandom_range(0, 1) ? '1 : '0;
               default: cost = $urandom;
            endcase
            tag = TAG_W'($urandom);
            if (table_fill > 0 && $urandom_range(0, 9) < 7)
               rank = RANK_W'($urandom_range(0, table_fill - 1));
            else
               rank = RANK_W'($urandom_range(0, DEPTH - 1));
            send_request(op, cost, tag, rank);
            predicted = apply_request(op, cost, tag, rank);
            expected_outcomes = {expected_outcomes, predicted};
         end
      end

      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
